[rtl/core/dapm_pkg.sv]
// shared codes and defaults for the lattice all-pairs distance block
// no dependencies
package dapm_pkg;

  localparam int DefMaxNodes = 64;
  localparam int DefMaxArcs  = 512;

  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_COMPUTE = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DROP  = 2'd1,
    STAT_RANGE = 2'd2
  } stat_t;

  localparam logic [2:0] RegNodeCount = 3'd0;

endpackage

[rtl/core/dapm_ram.sv]
// simple dual-port synchronous ram, one write and one registered read
// no dependencies
module dapm_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/dapm_relax.sv]
// merges one path through a successor row into a matrix entry
// entry layout {reach, short, long}; no dependencies
module dapm_relax #(
  parameter int NW = 7
) (
  input  logic [2*NW:0] tc,
  input  logic [2*NW:0] ic,
  input  logic          cost,
  output logic [2*NW:0] upd,
  output logic          we
);

  logic [NW-1:0] s;
  logic [NW-1:0] l;
  logic [NW-1:0] ic_s;
  logic [NW-1:0] ic_l;

  always_comb begin
    s    = tc[2*NW-1:NW] + NW'(cost);
    l    = tc[NW-1:0] + NW'(cost);
    ic_s = ic[2*NW-1:NW];
    ic_l = ic[NW-1:0];
    we   = tc[2*NW];
    if (!ic[2*NW]) begin
      upd = {1'b1, s, l};
    end else begin
      upd = {1'b1, (s < ic_s) ? s : ic_s, (l > ic_l) ? l : ic_l};
    end
  end

endmodule

[rtl/core/dag_all_pairs_min_max_distance.sv]
// all-pairs fewest/most word count over a loaded lattice, uses dapm_pkg
// instantiates dapm_ram (arc store, two matrix copies) and dapm_relax
// add arc and clear arcs: taken in the idle state; query: result registered via S_QRD, S_QOUT
// compute: clear of all (MAX_NODES+1)^2 matrix cells, then per row a scan of every stored arc
//   and an update of each matrix cell visited; matrix read-modify-write sets the pace
// reset: synchronous; a clearing pass over all (MAX_NODES+1)^2 matrix cells runs before any input
module dag_all_pairs_min_max_distance #(
  parameter int MAX_NODES = dapm_pkg::DefMaxNodes,
  parameter int MAX_ARCS  = dapm_pkg::DefMaxArcs
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [6:0]  from_node,
  input  logic [6:0]  arc_span,
  input  logic        counts_word,
  input  logic [6:0]  to_node,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_query_reply,
  output logic [1:0]  status,
  output logic        reachable,
  output logic [6:0]  short_dist,
  output logic [6:0]  long_dist,
  output logic [9:0]  edge_count
);
  import dapm_pkg::*;

  localparam int DIM = MAX_NODES + 1;
  localparam int NW  = $clog2(MAX_NODES + 1);
  localparam int EW  = 2 * NW + 1;
  localparam int AW  = $clog2(DIM * DIM);
  localparam int FW  = $clog2(MAX_ARCS + 1);
  localparam int IW  = $clog2(MAX_ARCS);
  localparam int CW  = 2 * NW + 1;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_CLR  = 10'b0000000010,
    S_ARD  = 10'b0000000100,
    S_ACHK = 10'b0000001000,
    S_MRD  = 10'b0000010000,
    S_MWR  = 10'b0000100000,
    S_QRD  = 10'b0001000000,
    S_QOUT = 10'b0010000000,
    S_DONE = 10'b0100000000,
    S_SPR  = 10'b1000000000
  } state_t;

  state_t        st;
  logic [NW-1:0] node_count;
  logic [FW-1:0] fill;
  logic          dropped;
  logic [NW-1:0] r;
  logic [NW-1:0] c;
  logic [NW-1:0] i;
  logic [NW-1:0] tnode;
  logic          cost;
  logic [FW-1:0] k;
  logic          clr_diag;
  logic [NW-1:0] qr;
  logic [NW-1:0] qc;
  logic          qbad;

  logic          accept;
  req_t          req;
  logic          arc_ok;
  logic [CW-1:0] arc_rd;
  logic [NW:0]   t;
  logic [EW-1:0] rd0;
  logic [EW-1:0] rd1;
  logic [EW-1:0] upd;
  logic          relax_we;
  logic          mat_we;
  logic [AW-1:0] mat_waddr;
  logic [EW-1:0] mat_wdata;
  logic [AW-1:0] raddr0;

  function automatic logic [AW-1:0] maddr(input logic [NW-1:0] rr, input logic [NW-1:0] cc);
    maddr = AW'(32'(rr) * DIM + 32'(cc));
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == RegNodeCount) ? 32'(node_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (psel && penable && pwrite && paddr == RegNodeCount) begin
      node_count <= (32'(pwdata[6:0]) > 32'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(pwdata[6:0]);
    end
  end

  assign req      = req_t'(req_type);
  assign in_ready = (st == S_IDLE) &&
                    (!out_valid || out_ready || req == REQ_ADD || req == REQ_CLEAR);
  assign accept   = in_valid && in_ready;
  assign arc_ok   = arc_span != 7'd0 &&
                    (32'(from_node) + 32'(arc_span) <= 32'(node_count)) &&
                    32'(fill) < 32'(MAX_ARCS);

  dapm_ram #(.W(CW), .D(MAX_ARCS)) u_arcs (
    .clk   (clk),
    .we    (accept && req == REQ_ADD && arc_ok),
    .waddr (fill[IW-1:0]),
    .wdata ({counts_word, NW'(arc_span), NW'(from_node)}),
    .raddr (k[IW-1:0]),
    .rdata (arc_rd)
  );

  // two copies give the successor-row read and the target read in the same cycle
  assign raddr0 = (st == S_QRD) ? maddr(qr, qc) : maddr(tnode, c);

  dapm_ram #(.W(EW), .D(DIM * DIM)) u_mat_t (
    .clk (clk), .we (mat_we), .waddr (mat_waddr), .wdata (mat_wdata),
    .raddr (raddr0), .rdata (rd0)
  );

  dapm_ram #(.W(EW), .D(DIM * DIM)) u_mat_i (
    .clk (clk), .we (mat_we), .waddr (mat_waddr), .wdata (mat_wdata),
    .raddr (maddr(i, c)), .rdata (rd1)
  );

  dapm_relax #(.NW(NW)) u_relax (
    .tc (rd0), .ic (rd1), .cost (cost), .upd (upd), .we (relax_we)
  );

  always_comb begin
    mat_we    = (st == S_CLR) || (st == S_MWR && relax_we);
    mat_waddr = (st == S_CLR) ? maddr(r, c) : maddr(i, c);
    if (st == S_CLR) begin
      mat_wdata = (clr_diag && r == c && r <= node_count) ? {1'b1, {(EW-1){1'b0}}} : '0;
    end else begin
      mat_wdata = upd;
    end
  end

  assign t = {1'b0, i} + {1'b0, arc_rd[2*NW-1:NW]};

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLR;
      fill      <= '0;
      dropped   <= 1'b0;
      r         <= '0;
      c         <= '0;
      k         <= '0;
      i         <= '0;
      clr_diag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (accept) begin
            unique case (req)
              REQ_ADD: begin
                if (arc_ok) begin
                  fill <= fill + FW'(1);
                end else begin
                  dropped <= 1'b1;
                end
              end
              REQ_CLEAR: begin
                fill    <= '0;
                dropped <= 1'b0;
              end
              REQ_COMPUTE: begin
                r        <= '0;
                c        <= '0;
                clr_diag <= 1'b1;
                st       <= S_CLR;
              end
              REQ_QUERY: begin
                qr   <= NW'(from_node);
                qc   <= NW'(to_node);
                qbad <= 32'(from_node) > 32'(node_count) || 32'(to_node) > 32'(node_count);
                st   <= S_QRD;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          if (c == NW'(MAX_NODES)) begin
            c <= '0;
            r <= r + NW'(1);
          end else begin
            c <= c + NW'(1);
          end
          if (r == NW'(MAX_NODES) && c == NW'(MAX_NODES)) begin
            if (!clr_diag) begin
              st <= S_IDLE;
            end else if (node_count == '0) begin
              st <= S_DONE;
            end else begin
              i  <= node_count - NW'(1);
              k  <= '0;
              st <= S_ARD;
            end
          end
        end
        S_ARD: begin
          if (k == fill) begin
            if (i == '0) begin
              st <= S_DONE;
            end else begin
              i <= i - NW'(1);
              k <= '0;
            end
          end else begin
            st <= S_ACHK;
          end
        end
        S_ACHK: begin
          k  <= k + FW'(1);
          st <= S_ARD;
          if (arc_rd[NW-1:0] == i) begin
            if (arc_rd[2*NW-1:NW] == '0 || t > {1'b0, node_count}) begin
              dropped <= 1'b1;
            end else begin
              tnode <= t[NW-1:0];
              c     <= t[NW-1:0];
              cost  <= arc_rd[2*NW];
              st    <= S_MRD;
            end
          end
        end
        S_MRD: begin
          st <= S_MWR;
        end
        S_MWR: begin
          if (c == node_count) begin
            st <= S_ARD;
          end else begin
            c  <= c + NW'(1);
            st <= S_MRD;
          end
        end
        S_QRD: begin
          st <= S_QOUT;
        end
        S_QOUT: begin
          out_valid <= 1'b1;
          st        <= S_IDLE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          st        <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (st == S_DONE) begin
      is_query_reply <= 1'b0;
      status         <= dropped ? STAT_DROP : STAT_OK;
      reachable      <= 1'b0;
      short_dist     <= '0;
      long_dist      <= '0;
      edge_count     <= 10'(fill);
    end else if (st == S_QOUT) begin
      is_query_reply <= 1'b1;
      edge_count     <= 10'(fill);
      if (qbad) begin
        status     <= STAT_RANGE;
        reachable  <= 1'b0;
        short_dist <= '0;
        long_dist  <= '0;
      end else begin
        status     <= dropped ? STAT_DROP : STAT_OK;
        reachable  <= rd0[EW-1];
        short_dist <= rd0[EW-1] ? 7'(rd0[2*NW-1:NW]) : 7'd0;
        long_dist  <= rd0[EW-1] ? 7'(rd0[NW-1:0]) : 7'd0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= 32'(MAX_ARCS))
    else $error("arc fill past store depth");

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (st == S_QOUT || st == S_DONE) |-> !out_valid)
    else $error("result produced while output slot busy");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    (st == S_MWR) |-> (i < tnode && c <= node_count))
    else $error("matrix update touches a row it reads");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (st == S_MRD || st == S_CLR) |-> !in_ready)
    else $error("transfer accepted during compute");

endmodule

[test/dag_all_pairs_min_max_distance_tb.sv]
// self-checking testbench for the lattice all-pairs fewest/most word count block
// depends on dapm_pkg and dag_all_pairs_min_max_distance; drives valid/ready and apb
`timescale 1ns / 100ps

module dag_all_pairs_min_max_distance_tb;
  import dapm_pkg::*;

  localparam int NodeLim   = 64;
  localparam int ArcLim    = 512;
  localparam int Dim       = NodeLim + 1;
  localparam int IdleLimit = 600000;
  localparam int Settle    = 8;

  typedef struct {
    logic       is_query_reply;
    logic [1:0] status;
    logic       reachable;
    logic [6:0] short_dist;
    logic [6:0] long_dist;
    logic [9:0] edge_count;
  } reply_t;

  class lattice_scoreboard;
    int     arc_from[ArcLim];
    int     arc_span_q[ArcLim];
    int     arc_word[ArcLim];
    int     fill;
    bit     dropped;
    int     nodes;
    int     fewest[Dim*Dim];
    int     most[Dim*Dim];
    bit     reach[Dim*Dim];
    reply_t replies_due[$];
    int     errors;

    function new();
      fill = 0; dropped = 0; nodes = 0; errors = 0;
      for (int i = 0; i < Dim*Dim; i++) begin
        fewest[i] = 0; most[i] = 0; reach[i] = 0;
      end
    endfunction

    function void set_nodes(logic [31:0] value);
      int v;
      v = value[6:0];
      nodes = (v > NodeLim) ? NodeLim : v;
    endfunction

    function void relax_all();
      int t, cost, tc, ic, s, l;
      for (int i = 0; i < Dim*Dim; i++) begin
        fewest[i] = 0; most[i] = 0; reach[i] = 0;
      end
      for (int i = 0; i <= nodes; i++) reach[i*Dim+i] = 1;
      for (int i = nodes - 1; i >= 0; i--) begin
        for (int k = 0; k < fill; k++) begin
          if (arc_from[k] != i) continue;
          t = i + arc_span_q[k];
          if (arc_span_q[k] == 0 || t > nodes) begin
            dropped = 1;
            continue;
          end
          cost = arc_word[k];
          for (int c = t; c <= nodes; c++) begin
            tc = t*Dim + c;
            ic = i*Dim + c;
            if (!reach[tc]) continue;
            s = cost + fewest[tc];
            l = cost + most[tc];
            if (!reach[ic]) begin
              reach[ic] = 1; fewest[ic] = s; most[ic] = l;
            end else begin
              if (s < fewest[ic]) fewest[ic] = s;
              if (l > most[ic]) most[ic] = l;
            end
          end
        end
      end
    endfunction

    // called on each accepted request transfer
    function void note_request(req_t req, int f, int sp, int w, int t);
      reply_t r;
      r.edge_count = fill[9:0];
      r.reachable = 0; r.short_dist = 0; r.long_dist = 0;
      case (req)
        REQ_ADD: begin
          if (sp == 0 || f + sp > nodes || fill >= ArcLim) dropped = 1;
          else begin
            arc_from[fill] = f; arc_span_q[fill] = sp; arc_word[fill] = w;
            fill++;
          end
        end
        REQ_CLEAR: begin
          fill = 0; dropped = 0;
        end
        REQ_COMPUTE: begin
          relax_all();
          r.is_query_reply = 0;
          r.status = dropped ? STAT_DROP : STAT_OK;
          replies_due = {replies_due, r};
        end
        default: begin
          r.is_query_reply = 1;
          if (f > nodes || t > nodes) r.status = STAT_RANGE;
          else begin
            r.status = dropped ? STAT_DROP : STAT_OK;
            if (reach[f*Dim+t]) begin
              r.reachable = 1;
              r.short_dist = 7'(fewest[f*Dim+t]);
              r.long_dist = 7'(most[f*Dim+t]);
            end
          end
          replies_due = {replies_due, r};
        end
      endcase
    endfunction

    function void check_reply(reply_t got);
      reply_t exp;
      if (replies_due.size() == 0) begin
        $error("unexpected reply transfer");
        errors++;
        return;
      end
      exp = replies_due.pop_front();
      if (got.is_query_reply !== exp.is_query_reply) begin
        $error("is_query_reply exp %0d got %0d", exp.is_query_reply, got.is_query_reply);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status exp %0d got %0d", exp.status, got.status); errors++;
      end
      if (got.reachable !== exp.reachable) begin
        $error("reachable exp %0d got %0d", exp.reachable, got.reachable); errors++;
      end
      if (got.short_dist !== exp.short_dist) begin
        $error("short_dist exp %0d got %0d", exp.short_dist, got.short_dist); errors++;
      end
      if (got.long_dist !== exp.long_dist) begin
        $error("long_dist exp %0d got %0d", exp.long_dist, got.long_dist); errors++;
      end
      if (got.edge_count !== exp.edge_count) begin
        $error("edge_count exp %0d got %0d", exp.edge_count, got.edge_count); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  req_type = '0;
  logic [6:0]  from_node = '0, arc_span = '0, to_node = '0;
  logic        counts_word = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        is_query_reply, reachable;
  logic [1:0]  status;
  logic [6:0]  short_dist, long_dist;
  logic [9:0]  edge_count;

  lattice_scoreboard sb = new();
  int idle_cycles = 0;
  int sent = 0;
  bit stall_free = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  dag_all_pairs_min_max_distance i_dut (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (stall_free || r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    if (stall_free) out_ready <= 1;
    else if ($urandom_range(0, 99) < 3) out_ready <= 0;
    else if (!out_ready && $urandom_range(0, 99) < 30) out_ready <= 1;
    else if (out_ready && $urandom_range(0, 99) < 20) out_ready <= 0;
    else if (!out_ready && $urandom_range(0, 99) < 10) out_ready <= 1;
  end

  always @(posedge clk) begin
    reply_t got;
    if (!rst && out_valid && out_ready) begin
      got.is_query_reply = is_query_reply;
      got.status = status;
      got.reachable = reachable;
      got.short_dist = short_dist;
      got.long_dist = long_dist;
      got.edge_count = edge_count;
      sb.check_reply(got);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("dag_all_pairs_min_max_distance_tb failed");
      $finish;
    end
  end

  task automatic send(req_t req, int f, int sp, int w, int t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1;
    req_type <= req;
    from_node <= f[6:0];
    arc_span <= sp[6:0];
    counts_word <= w[0];
    to_node <= t[6:0];
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, f, sp, w, t);
    sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk) in_valid <= 0;
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_nodes(logic [31:0] value);
    wait_drained();
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 3'(RegNodeCount * 4);
    pwdata <= value;
    @(negedge clk) penable <= 1;
    do @(posedge clk); while (!pready);
    sb.set_nodes(value);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic add_good(int n);
    int f;
    f = $urandom_range(0, n - 1);
    send(REQ_ADD, f, $urandom_range(1, n - f), $urandom_range(0, 1), $urandom_range(0, 127));
  endtask

  task automatic query_any(int n);
    if ($urandom_range(0, 9) == 0)
      send(REQ_QUERY, $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 1),
           $urandom_range(0, 127));
    else
      send(REQ_QUERY, $urandom_range(0, n), $urandom_range(0, 127), $urandom_range(0, 1),
           $urandom_range(0, n));
  endtask

  task automatic random_phase();
    int n, arcs, queries, r;
    r = $urandom_range(0, 19);
    if (r == 0) n = 0;
    else if (r == 1) n = 1;
    else if (r == 2) n = NodeLim;
    else if (r == 3) n = $urandom_range(65, 127);
    else n = $urandom_range(2, 12);
    write_nodes({25'($urandom_range(0, 32'h01ff_ffff)), n[6:0]});
    n = sb.nodes;
    if ($urandom_range(0, 2) != 0) send(REQ_CLEAR, $urandom_range(0, 127),
                                        $urandom_range(0, 127), $urandom_range(0, 1),
                                        $urandom_range(0, 127));
    arcs = $urandom_range(1, 24);
    for (int k = 0; k < arcs; k++) begin
      if (n == 0 || $urandom_range(0, 9) == 0)
        send(req_t'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom_range(0, 127),
             $urandom_range(0, 1), $urandom_range(0, 127));
      else add_good(n);
    end
    if (n > 1 && $urandom_range(0, 7) == 0) begin
      // shrink the lattice under already stored arcs
      write_nodes($urandom_range(0, n - 1));
      n = sb.nodes;
    end
    if ($urandom_range(0, 9) != 0)
      send(REQ_COMPUTE, $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 1),
           $urandom_range(0, 127));
    queries = $urandom_range(2, 20);
    for (int k = 0; k < queries; k++) query_any(n);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 0;

    // before any compute: matrices read as zero, node count zero
    send(REQ_QUERY, 0, 0, 0, 0);
    send(REQ_QUERY, 1, 0, 0, 0);
    send(REQ_ADD, 0, 1, 1, 0);
    send(REQ_COMPUTE, 0, 0, 0, 0);
    write_nodes(4);
    send(REQ_CLEAR, 0, 0, 0, 0);
    send(REQ_ADD, 0, 1, 1, 0);
    send(REQ_ADD, 1, 1, 0, 0);
    send(REQ_ADD, 0, 2, 1, 0);
    send(REQ_ADD, 2, 2, 1, 0);
    send(REQ_ADD, 1, 3, 1, 0);
    send(REQ_COMPUTE, 0, 0, 0, 0);
    send(REQ_QUERY, 0, 0, 0, 4);
    send(REQ_QUERY, 4, 0, 0, 0);
    send(REQ_QUERY, 3, 0, 0, 3);
    send(REQ_QUERY, 0, 0, 0, 5);
    send(REQ_ADD, 3, 2, 1, 0);
    send(REQ_ADD, 2, 0, 1, 0);
    send(REQ_QUERY, 0, 0, 0, 2);
    write_nodes(2);
    send(REQ_COMPUTE, 0, 0, 0, 0);
    send(REQ_QUERY, 0, 0, 0, 2);
    send(REQ_CLEAR, 0, 0, 0, 0);
    send(REQ_QUERY, 127, 0, 0, 127);
    write_nodes(32'hffff_ffff);
    send(REQ_ADD, 0, 64, 1, 0);
    send(REQ_ADD, 63, 1, 0, 0);
    send(REQ_COMPUTE, 0, 0, 0, 0);
    send(REQ_QUERY, 0, 0, 0, 64);

    // full arc store, then one arc too many
    send(REQ_CLEAR, 0, 0, 0, 0);
    for (int k = 0; k <= ArcLim; k++) add_good(NodeLim);
    send(REQ_QUERY, 0, 0, 0, 1);
    send(REQ_COMPUTE, 0, 0, 0, 0);
    query_any(NodeLim);
    send(REQ_CLEAR, 0, 0, 0, 0);

    while (sent < 900) begin
      if ($urandom_range(0, 5) == 0) stall_free = ~stall_free;
      random_phase();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    stall_free = 0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.replies_due.size() == 0) begin
      $display("dag_all_pairs_min_max_distance_tb passed");
    end else begin
      $display("dag_all_pairs_min_max_distance_tb failed");
    end
    $finish;
  end

endmodule
